@@ design/decimal_length_prefix_deframer_macros.svh @@
// Assertion helpers for the deframer.
`ifndef DECIMAL_LENGTH_PREFIX_DEFRAMER_MACROS_SVH
`define DECIMAL_LENGTH_PREFIX_DEFRAMER_MACROS_SVH

// Check that holds at every clock edge out of reset.
`define DLPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check of the form "cond holds, then next holds in the following cycle".
`define DLPD_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error(msg);

`endif

@@ design/dlpd_pkg.sv @@
package dlpd_pkg;

  localparam int PREFIX_DIGITS = 4;
  localparam int LEN_MAX       = 10 ** PREFIX_DIGITS - 1;
  localparam int LEN_W         = $clog2(LEN_MAX + 1);
  localparam int CNT_W         = $clog2(PREFIX_DIGITS + 1);

  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

  typedef enum logic [2:0] {
    KIND_PAYLOAD    = 3'd0,
    KIND_DONE       = 3'd1,
    KIND_BAD_DIGIT  = 3'd2,
    KIND_ZERO_LEN   = 3'd3,
    KIND_NO_NEWLINE = 3'd4
  } kind_e;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    kind_e      kind;
  } res_t;

  typedef struct packed {
    logic in_payload;
    logic left_zero;
  } status_t;

endpackage

@@ design/dlpd_in_stage.sv @@
module dlpd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       fire_i,
  output logic       vld_o,
  output logic [7:0] data_o
);
  import dlpd_pkg::*;

  logic       vld_q;
  logic [7:0] data_q;

  assign in_ready_o = !vld_q || fire_i;
  assign vld_o      = vld_q;
  assign data_o     = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      vld_q <= 1'b1;
    end else if (fire_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_byte_i;
    end
  end

endmodule

@@ design/dlpd_step.sv @@
module dlpd_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        data_i,
  output dlpd_pkg::res_t    res_o,
  output dlpd_pkg::status_t status_o
);
  import dlpd_pkg::*;

  logic             in_payload_q, in_payload_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [LEN_W-1:0] accum_q, accum_d;
  logic             bad_q, bad_d;
  logic [LEN_W-1:0] left_q, left_d;

  logic             is_digit;
  logic [3:0]       digit;
  logic [LEN_W+3:0] accum_wide;
  logic [LEN_W-1:0] accum_next;
  logic             bad_next;

  always_comb begin
    is_digit   = data_i inside {[CHAR_ZERO:CHAR_NINE]};
    digit      = 4'(data_i - CHAR_ZERO);
    accum_wide = ((LEN_W + 4)'(accum_q) << 3) + ((LEN_W + 4)'(accum_q) << 1)
                 + (LEN_W + 4)'(digit);
    accum_next = is_digit ? accum_wide[LEN_W-1:0] : accum_q;
    bad_next   = bad_q || !is_digit;

    in_payload_d = in_payload_q;
    cnt_d        = cnt_q;
    accum_d      = accum_q;
    bad_d        = bad_q;
    left_d       = left_q;
    res_o        = '{vld: 1'b0, data: 8'h00, kind: KIND_PAYLOAD};

    if (!in_payload_q) begin
      cnt_d   = cnt_q + CNT_W'(1);
      accum_d = accum_next;
      bad_d   = bad_next;
      if (cnt_q == CNT_W'(PREFIX_DIGITS - 1)) begin
        cnt_d   = '0;
        accum_d = '0;
        bad_d   = 1'b0;
        if (bad_next) begin
          res_o = '{vld: 1'b1, data: 8'h00, kind: KIND_BAD_DIGIT};
        end else if (accum_next == '0) begin
          res_o = '{vld: 1'b1, data: 8'h00, kind: KIND_ZERO_LEN};
        end else begin
          in_payload_d = 1'b1;
          left_d       = accum_next;
        end
      end
    end else if (left_q > LEN_W'(1)) begin
      left_d = left_q - LEN_W'(1);
      res_o  = '{vld: 1'b1, data: data_i, kind: KIND_PAYLOAD};
    end else begin
      in_payload_d = 1'b0;
      left_d       = '0;
      if (data_i == CHAR_NEWLINE) begin
        res_o = '{vld: 1'b1, data: 8'h00, kind: KIND_DONE};
      end else begin
        res_o = '{vld: 1'b1, data: 8'h00, kind: KIND_NO_NEWLINE};
      end
    end
  end

  assign status_o = '{in_payload: in_payload_q, left_zero: (left_q == '0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      cnt_q        <= '0;
      accum_q      <= '0;
      bad_q        <= 1'b0;
      left_q       <= '0;
    end else if (fire_i) begin
      in_payload_q <= in_payload_d;
      cnt_q        <= cnt_d;
      accum_q      <= accum_d;
      bad_q        <= bad_d;
      left_q       <= left_d;
    end
  end

endmodule

@@ design/dlpd_out_stage.sv @@
module dlpd_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  dlpd_pkg::res_t res_i,
  output logic           busy_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic [2:0]     out_kind_o
);
  import dlpd_pkg::*;

  logic       vld_q;
  logic [7:0] data_q;
  kind_e      kind_q;

  // Full and not draining this cycle: a new result cannot be taken.
  assign busy_o      = vld_q && !out_ready_i;
  assign out_valid_o = vld_q;
  assign out_byte_o  = data_q;
  assign out_kind_o  = kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= 1'b1;
    end else if (out_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i.data;
      kind_q <= res_i.kind;
    end
  end

endmodule

@@ design/decimal_length_prefix_deframer.sv @@
// Decimal length-prefix deframer. Takes one byte per beat and sustains one
// beat per cycle on both sides when neither side stalls. A byte is first
// captured in the input register, and its result is then loaded into the
// result register that drives out_valid, out_byte and out_kind. A
// held result that blocks a new one stalls the input register, and in_ready
// drops in that same cycle. Each frame opens with four ASCII digits giving
// a length L; L-1 payload beats follow (kind 0), then frame complete
// (kind 1) if the L-th byte is a newline, or missing newline (kind 4). A
// non-digit in the prefix gives bad digit (kind 2), and a zero length gives
// zero length (kind 3), both reported on the last prefix byte. Prefix bytes
// other than the last give no result. After any error or a finished frame,
// the next byte starts a new prefix.
`include "decimal_length_prefix_deframer_macros.svh"

module decimal_length_prefix_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] out_kind_o
);
  import dlpd_pkg::*;

  logic       s1_vld;
  logic [7:0] s1_data;
  logic       fire;
  logic       out_busy;
  res_t       res;
  status_t    status;

  assign fire = s1_vld && !(res.vld && out_busy);

  dlpd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .fire_i     (fire),
    .vld_o      (s1_vld),
    .data_o     (s1_data)
  );

  dlpd_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .data_i   (s1_data),
    .res_o    (res),
    .status_o (status)
  );

  dlpd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && res.vld),
    .res_i       (res),
    .busy_o      (out_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_kind_o  (out_kind_o)
  );

  `DLPD_ASSERT(a_payload_len_nz, !status.in_payload || !status.left_zero,
               "payload with no bytes left")
  `DLPD_ASSERT(a_payload_emits, !(status.in_payload && fire) || res.vld,
               "payload beat without result")
  `DLPD_ASSERT_NEXT(a_end_to_prefix, fire && res.vld && res.kind != KIND_PAYLOAD,
                    !status.in_payload, "frame end did not return to prefix")
  `DLPD_ASSERT_NEXT(a_load_shows, fire && res.vld, out_valid_o,
                    "loaded result not presented")

endmodule
